// ===== hw/rtl/text_traits_detector_assert.svh =====
// assertion macros for the text traits detector
// used by text_traits_detector.sv, no other dependencies
`ifndef TEXT_TRAITS_DETECTOR_ASSERT_SVH
`define TEXT_TRAITS_DETECTOR_ASSERT_SVH

// same-cycle implication, disabled in reset
`define TTD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("text_traits_detector: same-cycle check failed");

// next-cycle implication, disabled in reset
`define TTD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("text_traits_detector: next-cycle check failed");

`endif

// ===== hw/rtl/ttd_pkg.sv =====
// types and constants for the text traits detector
// no dependencies; used by text_traits_detector.sv
package ttd_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [1:0] line_ending;
    logic [2:0] encoding;
    logic       final_newline;
  } result_t;

  typedef enum logic [1:0] {
    BOM_NONE    = 2'd0,
    BOM_UTF8    = 2'd1,
    BOM_UTF16LE = 2'd2,
    BOM_UTF16BE = 2'd3
  } bom_kind_t;

  localparam logic [1:0] LE_NONE  = 2'd0;
  localparam logic [1:0] LE_LF    = 2'd1;
  localparam logic [1:0] LE_CRLF  = 2'd2;
  localparam logic [1:0] LE_MIXED = 2'd3;

  localparam logic [2:0] ENC_UTF8     = 3'd0;
  localparam logic [2:0] ENC_UTF8_BOM = 3'd1;
  localparam logic [2:0] ENC_UTF16LE  = 3'd2;
  localparam logic [2:0] ENC_UTF16BE  = 3'd3;
  localparam logic [2:0] ENC_BINARY   = 3'd4;
  localparam logic [2:0] ENC_NON_UTF8 = 3'd5;

  localparam logic [7:0] BYTE_NUL = 8'h00;
  localparam logic [7:0] BYTE_LF  = 8'h0A;
  localparam logic [7:0] BYTE_CR  = 8'h0D;
  localparam logic [7:0] BYTE_EF  = 8'hEF;
  localparam logic [7:0] BYTE_BB  = 8'hBB;
  localparam logic [7:0] BYTE_BF  = 8'hBF;
  localparam logic [7:0] BYTE_FF  = 8'hFF;
  localparam logic [7:0] BYTE_FE  = 8'hFE;

  localparam logic [7:0] ASCII_MAX  = 8'h7F;
  localparam logic [7:0] MASK_C0    = 8'hC0;
  localparam logic [7:0] MASK_E0    = 8'hE0;
  localparam logic [7:0] MASK_F0    = 8'hF0;
  localparam logic [7:0] MASK_F8    = 8'hF8;
  localparam logic [7:0] CONT_MARK  = 8'h80;
  localparam logic [7:0] LEAD2_MARK = 8'hC0;
  localparam logic [7:0] LEAD3_MARK = 8'hE0;
  localparam logic [7:0] LEAD4_MARK = 8'hF0;

  localparam logic [1:0] POS_MAX = 2'd3;

endpackage

// ===== hw/rtl/text_traits_detector.sv =====
// text traits detector: an accepted last word passes the input register, then scan logic
// into the result register to give its result word; one word per cycle while not stalled
// the scan state is updated once per word, so the feedback through the state registers sets rate
// result register frees while it is taken, so input keeps flowing when the result is not stalled
// reset (rst, synchronous) empties both registers and returns the scan state to file start
// depends on ttd_pkg.sv and text_traits_detector_assert.svh
module text_traits_detector (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  ttd_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output ttd_pkg::result_t result
);
  import ttd_pkg::*;

  `include "text_traits_detector_assert.svh"

  // input register
  logic  s1_valid;
  item_t s1;
  logic  s1_go;
  logic  out_free;

  // scan state
  logic [1:0] pos, pos_next;
  bom_kind_t  bom_kind, bom_kind_next;
  logic       bom_match, bom_match_next;
  logic       prev_cr, prev_cr_next;
  logic       prev_lf, prev_lf_next;
  logic       seen_bare_lf, seen_bare_lf_next;
  logic       seen_crlf, seen_crlf_next;
  logic       seen_nul, seen_nul_next;
  logic       utf8_bad, utf8_bad_next;
  logic [1:0] pending, pending_next;

  result_t    res_next;
  logic [7:0] b;

  assign out_free   = !result_valid || !result_stall;
  assign s1_go      = s1_valid && (!s1.last || out_free);
  assign item_stall = s1_valid && !s1_go;
  assign b          = s1.data_byte;

  always_comb begin
    pos_next          = pos;
    bom_kind_next     = bom_kind;
    bom_match_next    = bom_match;
    prev_cr_next      = prev_cr;
    prev_lf_next      = prev_lf;
    seen_bare_lf_next = seen_bare_lf;
    seen_crlf_next    = seen_crlf;
    seen_nul_next     = seen_nul;
    utf8_bad_next     = utf8_bad;
    pending_next      = pending;

    if (s1.has_byte) begin
      // byte-order mark tracking over the first three bytes
      if (bom_match && pos != POS_MAX) begin
        case (pos)
          2'd0: begin
            if (b == BYTE_EF) bom_kind_next = BOM_UTF8;
            else if (b == BYTE_FF) bom_kind_next = BOM_UTF16LE;
            else if (b == BYTE_FE) bom_kind_next = BOM_UTF16BE;
            else bom_match_next = 1'b0;
          end
          2'd1: begin
            if ((bom_kind == BOM_UTF8 && b != BYTE_BB) ||
                (bom_kind == BOM_UTF16LE && b != BYTE_FE) ||
                (bom_kind == BOM_UTF16BE && b != BYTE_FF)) bom_match_next = 1'b0;
          end
          default: begin
            if (bom_kind == BOM_UTF8 && b != BYTE_BF) bom_match_next = 1'b0;
          end
        endcase
      end

      // permissive utf-8 sequence check
      if (pending != 2'd0) begin
        if ((b & MASK_C0) != CONT_MARK) utf8_bad_next = 1'b1;
        pending_next = pending - 2'd1;
      end else if (b <= ASCII_MAX) begin
        pending_next = 2'd0;
      end else if ((b & MASK_E0) == LEAD2_MARK) begin
        pending_next = 2'd1;
      end else if ((b & MASK_F0) == LEAD3_MARK) begin
        pending_next = 2'd2;
      end else if ((b & MASK_F8) == LEAD4_MARK) begin
        pending_next = 2'd3;
      end else begin
        utf8_bad_next = 1'b1;
      end

      if (b == BYTE_NUL) seen_nul_next = 1'b1;
      if (b == BYTE_LF) begin
        if (prev_cr) seen_crlf_next = 1'b1;
        else seen_bare_lf_next = 1'b1;
      end
      prev_cr_next = (b == BYTE_CR);
      prev_lf_next = (b == BYTE_LF);
      if (pos != POS_MAX) pos_next = pos + 2'd1;
    end

    if (seen_bare_lf_next && seen_crlf_next) res_next.line_ending = LE_MIXED;
    else if (seen_crlf_next) res_next.line_ending = LE_CRLF;
    else if (seen_bare_lf_next) res_next.line_ending = LE_LF;
    else res_next.line_ending = LE_NONE;

    if (bom_match_next && bom_kind_next == BOM_UTF8 && pos_next == POS_MAX)
      res_next.encoding = ENC_UTF8_BOM;
    else if (bom_match_next && bom_kind_next == BOM_UTF16LE && pos_next >= 2'd2)
      res_next.encoding = ENC_UTF16LE;
    else if (bom_match_next && bom_kind_next == BOM_UTF16BE && pos_next >= 2'd2)
      res_next.encoding = ENC_UTF16BE;
    else if (seen_nul_next)
      res_next.encoding = ENC_BINARY;
    else if (utf8_bad_next || pending_next != 2'd0)
      res_next.encoding = ENC_NON_UTF8;
    else
      res_next.encoding = ENC_UTF8;

    res_next.final_newline = (pos_next == 2'd0) || prev_lf_next;
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall) begin
      s1 <= item;
    end
  end

  // scan state, back to file start after the last word
  always_ff @(posedge clk) begin
    if (rst || (s1_go && s1.last)) begin
      pos          <= 2'd0;
      bom_kind     <= BOM_NONE;
      bom_match    <= 1'b1;
      prev_cr      <= 1'b0;
      prev_lf      <= 1'b0;
      seen_bare_lf <= 1'b0;
      seen_crlf    <= 1'b0;
      seen_nul     <= 1'b0;
      utf8_bad     <= 1'b0;
      pending      <= 2'd0;
    end else if (s1_go) begin
      pos          <= pos_next;
      bom_kind     <= bom_kind_next;
      bom_match    <= bom_match_next;
      prev_cr      <= prev_cr_next;
      prev_lf      <= prev_lf_next;
      seen_bare_lf <= seen_bare_lf_next;
      seen_crlf    <= seen_crlf_next;
      seen_nul     <= seen_nul_next;
      utf8_bad     <= utf8_bad_next;
      pending      <= pending_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_go && s1.last) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1.last) begin
      result <= res_next;
    end
  end

  `TTD_ASSERT_NEXT(a_last_gives_result, clk, rst, s1_go && s1.last, result_valid)
  `TTD_ASSERT_NEXT(a_state_cleared, clk, rst, s1_go && s1.last,
    pos == 2'd0 && bom_match && pending == 2'd0 && !seen_nul)
  `TTD_ASSERT_NOW(a_stall_only_when_full, clk, rst, item_stall,
    s1_valid && s1.last && result_valid && result_stall)
  `TTD_ASSERT_NOW(a_encoding_code, clk, rst, result_valid,
    result.encoding <= ENC_NON_UTF8)

endmodule
